>>> rtl/mac_pkg.sv
// shared constants, codes and types for the moving average crossover unit
package mac_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int FRAC_W         = 16;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int WINDOW_MAX_DEF = 256;
    localparam int ALPHA_SHIFT    = 17;
    localparam int ALPHA_W        = ALPHA_SHIFT;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 9'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN,
        CFG_AVERAGE_MODE
    } cfg_index_t;

    typedef enum logic {
        MODE_SIMPLE,
        MODE_EXP
    } avg_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_EMA,
        ST_DONE
    } mac_state_t;

endpackage

>>> rtl/mac_stream_if.sv
// valid/ready channels for samples and results
interface mac_sample_if;
    logic                          valid;
    logic                          ready;
    logic [mac_pkg::SAMPLE_W-1:0]  sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface mac_result_if;
    logic                          valid;
    logic                          ready;
    logic [mac_pkg::SAMPLE_W-1:0]  average;
    logic                          average_valid;
    logic                          cross_above;
    logic                          cross_below;

    modport source (output valid, output average, output average_valid,
                    output cross_above, output cross_below, input ready);
    modport sink   (input valid, input average, input average_valid,
                    input cross_above, input cross_below, output ready);
endinterface

>>> rtl/moving_average_crossover_unit.sv
// moving average crossover unit: sample ring, running sum, sma/ema and crossing flags
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------------
//  samples   | in  | valid/ready   | sample[31:0], restart
//  results   | out | valid/ready   | average[31:0], average_valid, cross_above/below
//  cfg       | in  | cfg_we        | cfg_index, cfg_data[8:0]
//
//  one request at a time; a bit-serial divider produces sum/window for a simple average
//  or the first full window, and the smoothing factor for an exponential update; while
//  the window fills no division is done
//  ring read and write share one address of the single-port sample memory
//  rst_n clears series state and resets the control registers; datapath registers and ring contents are not cleared
//  a result waiting in the output register holds the next request in its done cycle
module moving_average_crossover_unit #(
    parameter int WINDOW_MAX = mac_pkg::WINDOW_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mac_sample_if.sink                    samples,
    mac_result_if.source                  results,
    input  logic                          cfg_we,
    input  logic [mac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mac_pkg::CFG_W-1:0]     cfg_data
);
    import mac_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int DIV_W  = WIN_W + 1;
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int PROD_W = ALPHA_W + SAMPLE_W;
    localparam int STEP_W = PROD_W - FRAC_W + 1;
    localparam int EXT_W  = STEP_W + 1;

    localparam logic [SUM_W-1:0]  ALPHA_DIVIDEND = SUM_W'(1) << ALPHA_SHIFT;
    localparam logic [PROD_W:0]   ROUND_UP       = (PROD_W+1)'((1 << FRAC_W) - 1);
    localparam logic [EXT_W-1:0]  SAMPLE_MAX     = EXT_W'({SAMPLE_W{1'b1}});

    logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                ring_we;

    mac_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    window_len_reg, window_len_next;
    avg_mode_t           mode_reg, mode_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [WIN_W-1:0]    seen_reg, seen_next;
    logic [SAMPLE_W-1:0] ema_reg, ema_next;
    logic [SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic [SAMPLE_W-1:0] prev_avg_reg, prev_avg_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic                valid_reg, valid_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [DIV_W-1:0]    divisor_reg, divisor_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                div_alpha_reg, div_alpha_next;
    logic [ALPHA_W-1:0]  alpha_reg, alpha_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic                res_valid_reg, res_valid_next;
    logic [SAMPLE_W-1:0] res_avg_reg, res_avg_next;
    logic                res_avalid_reg, res_avalid_next;
    logic                res_above_reg, res_above_next;
    logic                res_below_reg, res_below_next;

    logic [WIN_W-1:0]    win_eff;
    logic                was_full;
    logic [SUM_W-1:0]    sum_new;
    logic [WIN_W-1:0]    seen_new;
    logic [DIV_W:0]      trial;
    logic [SAMPLE_W-1:0] diff_mag;
    logic [STEP_W-1:0]   step;
    logic [PROD_W:0]     prod_round;
    logic [EXT_W-1:0]    ema_ext;
    logic                out_free;

    // effective window
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (32'(window_len_reg) > WINDOW_MAX)
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WIN_W'(window_len_reg);
        end
    end

    assign samples.ready         = (state_reg == ST_IDLE);
    assign results.valid         = res_valid_reg;
    assign results.average       = res_avg_reg;
    assign results.average_valid = res_avalid_reg;
    assign results.cross_above   = res_above_reg;
    assign results.cross_below   = res_below_reg;
    assign out_free              = !res_valid_reg || results.ready;

    assign was_full   = (seen_reg >= win_eff);
    assign sum_new    = sum_reg - (was_full ? SUM_W'(rd_data_reg) : '0) + SUM_W'(x_reg);
    assign seen_new   = was_full ? seen_reg : seen_reg + WIN_W'(1);
    assign trial      = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff_mag   = (x_reg < ema_reg) ? (ema_reg - x_reg) : (x_reg - ema_reg);
    assign prod_round = {1'b0, prod_reg} + ROUND_UP;
    assign step       = neg_reg ? STEP_W'(prod_round >> FRAC_W)
                                : STEP_W'(prod_reg >> FRAC_W);

    // exponential update with saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (EXT_W'(step) > EXT_W'(ema_reg))
            begin
                ema_ext = '0;
            end
            else
            begin
                ema_ext = EXT_W'(ema_reg) - EXT_W'(step);
            end
        end
        else
        begin
            ema_ext = EXT_W'(ema_reg) + EXT_W'(step);
            if (ema_ext > SAMPLE_MAX)
            begin
                ema_ext = SAMPLE_MAX;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        window_len_next  = window_len_reg;
        mode_next        = mode_reg;
        x_next           = x_reg;
        ptr_next         = ptr_reg;
        sum_next         = sum_reg;
        seen_next        = seen_reg;
        ema_next         = ema_reg;
        prev_sample_next = prev_sample_reg;
        prev_avg_next    = prev_avg_reg;
        prev_valid_next  = prev_valid_reg;
        avg_next         = avg_reg;
        valid_next       = valid_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        divisor_next     = divisor_reg;
        cnt_next         = cnt_reg;
        div_alpha_next   = div_alpha_reg;
        alpha_next       = alpha_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        res_valid_next   = res_valid_reg && !results.ready;
        res_avg_next     = res_avg_reg;
        res_avalid_next  = res_avalid_reg;
        res_above_next   = res_above_reg;
        res_below_next   = res_below_reg;
        ring_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    case (cfg_index)
                        CFG_WINDOW_LEN:   window_len_next = cfg_data;
                        CFG_AVERAGE_MODE: mode_next = avg_mode_t'(cfg_data[0]);
                        default:          window_len_next = window_len_reg;
                    endcase
                    ptr_next        = '0;
                    sum_next        = '0;
                    seen_next       = '0;
                    ema_next        = '0;
                    prev_sample_next = '0;
                    prev_avg_next   = '0;
                    prev_valid_next = 1'b0;
                end
                else if (samples.valid)
                begin
                    x_next = samples.sample;
                    if (samples.restart)
                    begin
                        ptr_next         = '0;
                        sum_next         = '0;
                        seen_next        = '0;
                        ema_next         = '0;
                        prev_sample_next = '0;
                        prev_avg_next    = '0;
                        prev_valid_next  = 1'b0;
                    end
                    else if (32'(ptr_reg) >= 32'(win_eff))
                    begin
                        ptr_next = '0;
                    end
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                ring_we   = 1'b1;
                sum_next  = sum_new;
                seen_next = seen_new;
                if (32'(ptr_reg) + 1 >= 32'(win_eff))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
                rem_next = '0;
                cnt_next = CNT_W'(SUM_W);
                if (seen_new < win_eff)
                begin
                    valid_next = 1'b0;
                    avg_next   = '0;
                    state_next = ST_DONE;
                end
                else if (mode_reg == MODE_SIMPLE || !was_full)
                begin
                    valid_next     = 1'b1;
                    dvd_next       = sum_new;
                    divisor_next   = DIV_W'(win_eff);
                    div_alpha_next = 1'b0;
                    state_next     = ST_DIV;
                end
                else
                begin
                    valid_next     = 1'b1;
                    dvd_next       = ALPHA_DIVIDEND;
                    divisor_next   = DIV_W'(win_eff) + DIV_W'(1);
                    div_alpha_next = 1'b1;
                    state_next     = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    if (trial >= {1'b0, divisor_reg})
                    begin
                        rem_next = DIV_W'(trial - {1'b0, divisor_reg});
                        dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[DIV_W-1:0];
                        dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else if (div_alpha_reg)
                begin
                    alpha_next = dvd_reg[ALPHA_W-1:0];
                    state_next = ST_MUL;
                end
                else
                begin
                    avg_next = dvd_reg[SAMPLE_W-1:0];
                    if (mode_reg == MODE_EXP)
                    begin
                        ema_next = dvd_reg[SAMPLE_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end

            ST_MUL:
            begin
                neg_next   = (x_reg < ema_reg);
                prod_next  = PROD_W'(alpha_reg) * PROD_W'(diff_mag);
                state_next = ST_EMA;
            end

            ST_EMA:
            begin
                ema_next   = ema_ext[SAMPLE_W-1:0];
                avg_next   = ema_ext[SAMPLE_W-1:0];
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_avg_next     = avg_reg;
                    res_avalid_next  = valid_reg;
                    res_above_next   = valid_reg && prev_valid_reg && (x_reg > avg_reg)
                                       && (prev_sample_reg <= prev_avg_reg);
                    res_below_next   = valid_reg && prev_valid_reg && (x_reg < avg_reg)
                                       && (prev_sample_reg >= prev_avg_reg);
                    prev_sample_next = x_reg;
                    prev_avg_next    = avg_reg;
                    prev_valid_next  = valid_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sample ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ptr_reg] <= x_reg;
        end
        rd_data_reg <= ring_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_len_reg  <= WINDOW_LEN_RESET;
            mode_reg        <= MODE_SIMPLE;
            ptr_reg         <= '0;
            sum_reg         <= '0;
            seen_reg        <= '0;
            ema_reg         <= '0;
            prev_sample_reg <= '0;
            prev_avg_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            valid_reg       <= 1'b0;
            cnt_reg         <= '0;
            div_alpha_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_len_reg  <= window_len_next;
            mode_reg        <= mode_next;
            ptr_reg         <= ptr_next;
            sum_reg         <= sum_next;
            seen_reg        <= seen_next;
            ema_reg         <= ema_next;
            prev_sample_reg <= prev_sample_next;
            prev_avg_reg    <= prev_avg_next;
            prev_valid_reg  <= prev_valid_next;
            valid_reg       <= valid_next;
            cnt_reg         <= cnt_next;
            div_alpha_reg   <= div_alpha_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        avg_reg        <= avg_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        divisor_reg    <= divisor_next;
        alpha_reg      <= alpha_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_avg_reg    <= res_avg_next;
        res_avalid_reg <= res_avalid_next;
        res_above_reg  <= res_above_next;
        res_below_reg  <= res_below_next;
    end

`ifndef SYNTHESIS
    a_cross_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.cross_above && results.cross_below))
        else $error("both crossing flags set");

    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.average_valid) |->
        (results.average == '0 && !results.cross_above && !results.cross_below))
        else $error("result without valid average carries data");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second request taken while busy");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= win_eff)
        else $error("sample count beyond window");
`endif

endmodule

>>> verif/testbench.sv
// testbench for the moving average crossover unit: request driver, result checker, predictor
`timescale 1ns / 1ps

module testbench;
    import mac_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } sample_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                average_valid;
        logic                cross_above;
        logic                cross_below;
    } crossover_result_t;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 3000;
    localparam int REPORT_LIMIT    = 200;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    cfg_index_t     cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mac_sample_if samples_bus ();
    mac_result_if results_bus ();

    moving_average_crossover_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_bus),
        .results   (results_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sample_req_t       pending_reqs[$];
    crossover_result_t expected_results[$];
    sample_req_t       next_req;
    int unsigned       queued_reqs;
    int unsigned       accepted_reqs;
    int unsigned       mismatches;
    int unsigned       sender_idle_pct;
    int unsigned       receiver_idle_pct;
    int unsigned       hold_left;
    int unsigned       quiet_cycles;
    bit                hold_request;

    // predictor state and its copy of the registers
    logic [CFG_W-1:0]    win_reg;
    avg_mode_t           mode_reg;
    logic [SAMPLE_W-1:0] hist_ring [WINDOW_MAX_DEF];
    int unsigned         hist_ptr;
    int unsigned         hist_count;
    logic [63:0]         hist_sum;
    logic [SAMPLE_W-1:0] smooth_avg;
    logic [SAMPLE_W-1:0] last_sample;
    logic [SAMPLE_W-1:0] last_avg;
    logic                last_valid;

    function automatic int unsigned effective_window();
        if (win_reg == '0)
            return 1;
        if (win_reg > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return 32'(win_reg);
    endfunction

    function automatic void clear_history();
        foreach (hist_ring[i])
            hist_ring[i] = '0;
        hist_ptr    = 0;
        hist_count  = 0;
        hist_sum    = '0;
        smooth_avg  = '0;
        last_sample = '0;
        last_avg    = '0;
        last_valid  = 1'b0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] ema_step(logic [SAMPLE_W-1:0] ema,
                                                     logic [SAMPLE_W-1:0] x,
                                                     int unsigned w);
        longint alpha;
        longint xl;
        longint el;
        longint updated;
        alpha   = (longint'(1) << (FRAC_W + 1)) / longint'(w + 1);
        xl      = longint'(x);
        el      = longint'(ema);
        updated = el + ((alpha * (xl - el)) >>> FRAC_W);
        if (updated < 0)
            updated = 0;
        if (updated > longint'(32'hFFFF_FFFF))
            updated = longint'(32'hFFFF_FFFF);
        return updated[SAMPLE_W-1:0];
    endfunction

    function automatic crossover_result_t predict_crossover(logic [SAMPLE_W-1:0] x,
                                                            logic restart);
        crossover_result_t r;
        int unsigned       w;
        int unsigned       idx;
        logic              was_full;
        r = '0;
        w = effective_window();
        if (restart)
            clear_history();
        if (hist_ptr >= w)
            hist_ptr = 0;
        idx      = hist_ptr;
        was_full = hist_count >= w;
        if (was_full)
            hist_sum -= hist_ring[idx];
        hist_sum      += x;
        hist_ring[idx] = x;
        hist_ptr       = (hist_ptr + 1 >= w) ? 0 : hist_ptr + 1;
        if (hist_count < w)
            hist_count++;
        if (hist_count >= w)
        begin
            r.average_valid = 1'b1;
            if (mode_reg == MODE_SIMPLE)
            begin
                r.average = SAMPLE_W'(hist_sum / w);
            end
            else
            begin
                smooth_avg = was_full ? ema_step(smooth_avg, x, w) : SAMPLE_W'(hist_sum / w);
                r.average  = smooth_avg;
            end
        end
        if (r.average_valid && last_valid)
        begin
            r.cross_above = (x > r.average) && (last_sample <= last_avg);
            r.cross_below = (x < r.average) && (last_sample >= last_avg);
        end
        last_sample = x;
        last_avg    = r.average;
        last_valid  = r.average_valid;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] level,
                                                        int unsigned spread);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return '0;
        if (roll < 6)
            return '1;
        if (roll < 12)
            return $urandom;
        return level + SAMPLE_W'($urandom_range(spread)) - SAMPLE_W'(spread / 2);
    endfunction

    task automatic push_req(logic [SAMPLE_W-1:0] s, logic r);
        pending_reqs.push_back('{sample: s, restart: r});
        queued_reqs++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (accepted_reqs != queued_reqs || expected_results.size() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(logic [CFG_W-1:0] win, avg_mode_t mode,
                                int unsigned count, bit write_regs);
        logic [SAMPLE_W-1:0] level;
        int unsigned         spread;
        if (write_regs)
        begin
            write_reg(CFG_WINDOW_LEN, win);
            write_reg(CFG_AVERAGE_MODE, CFG_W'(mode));
        end
        level = $urandom;
        case ($urandom_range(3))
            0: spread = 64;
            1: spread = 1 << 12;
            2: spread = 1 << 20;
            default: spread = 1 << 28;
        endcase
        repeat (count)
            push_req(pick_sample(level, spread), $urandom_range(99) < 3);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            samples_bus.valid   <= 1'b0;
            samples_bus.sample  <= '0;
            samples_bus.restart <= 1'b0;
        end
        else
        begin
            if (samples_bus.valid && samples_bus.ready)
            begin
                expected_results.push_back(
                    predict_crossover(samples_bus.sample, samples_bus.restart));
                accepted_reqs++;
            end
            if (!samples_bus.valid || samples_bus.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_req = pending_reqs.pop_front();
                    samples_bus.valid   <= 1'b1;
                    samples_bus.sample  <= next_req.sample;
                    samples_bus.restart <= next_req.restart;
                end
                else
                begin
                    samples_bus.valid <= 1'b0;
                end
            end
        end
    end

    // register writes seen by the predictor
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LEN:   win_reg  = cfg_data;
                CFG_AVERAGE_MODE: mode_reg = avg_mode_t'(cfg_data[0]);
                default:          ;
            endcase
            clear_history();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        crossover_result_t got;
        crossover_result_t want;
        if (!rst_n)
        begin
            results_bus.ready <= 1'b0;
        end
        else
        begin
            if (results_bus.valid && results_bus.ready)
            begin
                got = '{results_bus.average, results_bus.average_valid,
                        results_bus.cross_above, results_bus.cross_below};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual %p",
                                 $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch, expected avg=%h valid=%b ",
                                      "above=%b below=%b, actual avg=%h valid=%b ",
                                      "above=%b below=%b"},
                                     $time, want.average, want.average_valid,
                                     want.cross_above, want.cross_below,
                                     got.average, got.average_valid,
                                     got.cross_above, got.cross_below);
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_bus.ready <= 1'b0;
            end
            else
            begin
                results_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_bus.valid && samples_bus.ready) ||
                (results_bus.valid && results_bus.ready) || cfg_we)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int unsigned      k;
        int unsigned      roll;
        int unsigned      eff;
        int unsigned      count;
        logic [CFG_W-1:0] win;
        avg_mode_t        mode;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_WINDOW_LEN;
        cfg_data            = '0;
        samples_bus.valid   = 1'b0;
        samples_bus.sample  = '0;
        samples_bus.restart = 1'b0;
        results_bus.ready   = 1'b0;
        queued_reqs         = 0;
        accepted_reqs       = 0;
        mismatches          = 0;
        hold_left           = 0;
        hold_request        = 1'b0;
        quiet_cycles        = 0;
        sender_idle_pct     = 11;
        receiver_idle_pct   = 47;
        win_reg             = WINDOW_LEN_RESET;
        mode_reg            = MODE_SIMPLE;
        clear_history();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window of 20, simple average
        random_phase('0, MODE_SIMPLE, 26, 1'b0);

        // two-sample window, full-scale swings cross both ways, then a restart
        write_reg(CFG_WINDOW_LEN, 9'd2);
        write_reg(CFG_AVERAGE_MODE, CFG_W'(MODE_SIMPLE));
        push_req(32'h0, 1'b1);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h0, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h5, 1'b1);
        push_req(32'h7, 1'b0);
        drain();

        // zero window acts as one, ema tracks the sample exactly
        write_reg(CFG_WINDOW_LEN, 9'd0);
        write_reg(CFG_AVERAGE_MODE, CFG_W'(MODE_EXP));
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h0, 1'b0);
        push_req(32'h1234_5678, 1'b0);
        drain();

        // ema with full-scale steps in both directions
        write_reg(CFG_WINDOW_LEN, 9'd3);
        push_req(32'h0, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h0, 1'b0);
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h1, 1'b0);
        push_req(32'h9, 1'b1);
        drain();

        // window above the maximum, series never fills
        write_reg(CFG_WINDOW_LEN, 9'd511);
        write_reg(CFG_AVERAGE_MODE, CFG_W'(MODE_SIMPLE));
        push_req(32'hFFFF_FFFF, 1'b0);
        push_req(32'h0, 1'b0);
        push_req(32'h1, 1'b0);
        drain();

        for (k = 0; k < 9; k++)
        begin
            if (k == 3)
            begin
                sender_idle_pct   = 47;
                receiver_idle_pct = 11;
            end
            else if (k == 6)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            mode = avg_mode_t'($urandom_range(1));
            if (k == 2)
            begin
                random_phase(9'd256, MODE_SIMPLE, 262, 1'b1);
            end
            else if (k == 6)
            begin
                random_phase(9'd64, MODE_EXP, 72, 1'b1);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    win = CFG_W'($urandom_range(1, 8));
                else if (roll < 85)
                    win = CFG_W'($urandom_range(9, 40));
                else if (roll < 92)
                    win = '0;
                else
                    win = CFG_W'($urandom_range(257, 511));
                eff   = (win == '0) ? 1 : (win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : 32'(win);
                count = (eff > 40) ? $urandom_range(5, 15) : eff + $urandom_range(4, 16);
                // receiver holds off while requests keep coming
                if (k == 1)
                    hold_request = 1'b1;
                random_phase(win, mode, count, 1'b1);
            end
        end

        repeat (60) @(posedge clk);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
